// File: rtl/tridiagonal_system_solver_assert.svh
// Assertion macros for the tridiagonal solver RTL.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tss assertion failed");
`define TSS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("tss assertion failed");
`else
`define TSS_ASSERT(label, clk, rst_n, prop)
`define TSS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/tss_pkg.sv
// Shared types, states and saturation helper of the tridiagonal solver.
package tss_pkg;
	localparam int DW = 32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULP,
		S_MULQ,
		S_NUM,
		S_DIV,
		S_STORE,
		S_BK_RD,
		S_BK_MUL,
		S_BK_ADD,
		S_BK_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_p;
		logic mul_q;
		logic div_start;
		logic store;
		logic last;
		logic clear_run;
		logic bk_read;
		logic bk_mul;
		logic bk_add;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic pivot_zero;
	} sts_t;

	function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			sat32 = {1'b0, {(DW-1){1'b1}}};
		end else if (v < lo) begin
			sat32 = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat32 = v[DW-1:0];
		end
	endfunction
endpackage

// File: rtl/tss_div.sv
// Dual restoring divider sharing one divisor, one quotient bit per cycle.
module tss_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [tss_pkg::DW:0]     num0,
	input  logic signed [tss_pkg::DW:0]     num1,
	input  logic signed [tss_pkg::DW-1:0]   den,
	output logic                            done,
	output logic signed [tss_pkg::DW-1:0]   quo0,
	output logic signed [tss_pkg::DW-1:0]   quo1
);
	localparam int DW = tss_pkg::DW;
	localparam int W  = DW + FRAC_BITS;
	localparam int NW = $clog2(W);

	logic [DW-1:0] dvs_q;
	logic          dzero_q;
	logic [W-1:0]  dd0_q, dd1_q;
	logic [DW-1:0] rem0_q, rem1_q;
	logic          neg0_q, neg1_q, nz0_q, nz1_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q, done_q;

	logic [DW:0]   tr0, tr1;
	logic          ge0, ge1;
	logic [DW:0]   an0, an1;
	logic [DW:0]   ad;

	assign an0 = num0[DW] ? (DW+1)'(-num0) : num0;
	assign an1 = num1[DW] ? (DW+1)'(-num1) : num1;
	assign ad  = den[DW-1] ? (DW+1)'(-$signed({den[DW-1], den})) : {1'b0, den};
	assign tr0 = {rem0_q, dd0_q[W-1]};
	assign tr1 = {rem1_q, dd1_q[W-1]};
	assign ge0 = tr0 >= {1'b0, dvs_q};
	assign ge1 = tr1 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == NW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q   <= ad[DW-1:0];
			dzero_q <= (den == '0);
			dd0_q   <= {an0[DW-1:0], {FRAC_BITS{1'b0}}};
			dd1_q   <= {an1[DW-1:0], {FRAC_BITS{1'b0}}};
			rem0_q  <= '0;
			rem1_q  <= '0;
			neg0_q  <= num0[DW] ^ den[DW-1];
			neg1_q  <= num1[DW] ^ den[DW-1];
			nz0_q   <= (num0 != '0);
			nz1_q   <= (num1 != '0);
		end else if (busy_q) begin
			rem0_q <= ge0 ? DW'(tr0 - {1'b0, dvs_q}) : tr0[DW-1:0];
			rem1_q <= ge1 ? DW'(tr1 - {1'b0, dvs_q}) : tr1[DW-1:0];
			dd0_q  <= {dd0_q[W-2:0], ge0};
			dd1_q  <= {dd1_q[W-2:0], ge1};
		end
	end

	function automatic logic signed [DW-1:0] finish(
		input logic [W-1:0] mag, input logic neg, input logic nz, input logic dz
	);
		logic signed [DW-1:0] mx;
		logic signed [DW-1:0] mn;
		mx = {1'b0, {(DW-1){1'b1}}};
		mn = {1'b1, {(DW-1){1'b0}}};
		if (dz) begin
			finish = !nz ? '0 : (neg ? mn : mx);
		end else if (neg) begin
			finish = (mag > W'({1'b1, {(DW-1){1'b0}}})) ? mn : DW'(-mag);
		end else begin
			finish = (mag > W'(mx)) ? mx : mag[DW-1:0];
		end
	endfunction

	assign done = done_q;
	assign quo0 = finish(dd0_q, neg0_q, nz0_q, dzero_q);
	assign quo1 = finish(dd1_q, neg1_q, nz1_q, dzero_q);
endmodule

// File: rtl/tss_dpath.sv
// Datapath: row registers, shared multiplier, divider and coefficient stores.
module tss_dpath #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16,
	parameter int AW        = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tss_pkg::cmd_t                  cmd,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [AW-1:0]                  rd_addr,
	input  logic signed [tss_pkg::DW-1:0]  sub_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  main_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  super_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  right_side,
	output tss_pkg::sts_t                  sts,
	output logic signed [tss_pkg::DW-1:0]  solution
);
	localparam int DW = tss_pkg::DW;

	logic signed [DW-1:0] a_q, b_q, c_q, r_q;
	logic signed [DW-1:0] pp_q, qp_q, pivot_q, x_q;
	logic signed [DW-1:0] rdp_q, rdq_q;
	logic signed [63:0]   prod_q, prod_sh;
	logic signed [DW-1:0] opx, opy;
	logic signed [DW:0]   n0, n1;
	logic signed [DW-1:0] quo0, quo1, pval;
	logic                 div_done;

	logic signed [DW-1:0] mem_p [MAX_ROWS];
	logic signed [DW-1:0] mem_q [MAX_ROWS];

	assign prod_sh = prod_q >>> FRAC_BITS;

	always_comb begin
		opx = a_q;
		opy = pp_q;
		if (cmd.mul_q) begin
			opy = qp_q;
		end else if (cmd.bk_mul) begin
			opx = rdp_q;
			opy = x_q;
		end
	end

	assign n0   = cmd.last ? '0 : -$signed({c_q[DW-1], c_q});
	assign n1   = (DW+1)'(tss_pkg::sat32(64'(r_q) - prod_sh));
	assign pval = cmd.last ? '0 : quo0;

	tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num0   (n0),
		.num1   (n1),
		.den    (pivot_q),
		.done   (div_done),
		.quo0   (quo0),
		.quo1   (quo1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q <= '0;
			qp_q <= '0;
		end else if (cmd.clear_run) begin
			pp_q <= '0;
			qp_q <= '0;
		end else if (cmd.store) begin
			pp_q <= pval;
			qp_q <= quo1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= sub_diagonal;
			b_q <= main_diagonal;
			c_q <= super_diagonal;
			r_q <= right_side;
		end
		if (cmd.mul_p || cmd.mul_q || cmd.bk_mul) begin
			prod_q <= opx * opy;
		end
		if (cmd.mul_q) begin
			pivot_q <= tss_pkg::sat32(64'(b_q) + prod_sh);
		end
		if (cmd.store) begin
			mem_p[wr_addr] <= pval;
			mem_q[wr_addr] <= quo1;
		end
		if (cmd.bk_read) begin
			rdp_q <= mem_p[rd_addr];
			rdq_q <= mem_q[rd_addr];
		end
		if (cmd.bk_add) begin
			x_q <= cmd.first ? rdq_q : tss_pkg::sat32(prod_sh + 64'(rdq_q));
		end
	end

	assign sts.div_done   = div_done;
	assign sts.pivot_zero = (pivot_q == '0);
	assign solution       = x_q;
endmodule

// File: rtl/tss_ctrl.sv
// Controller: row sequencing, row count, run flags and result handshake.
`include "tridiagonal_system_solver_assert.svh"
module tss_ctrl #(
	parameter int MAX_ROWS = 64,
	parameter int AW       = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             last_row,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [5:0]       row_index,
	output logic             final_element,
	output logic             singular,
	output logic             overflowed,
	input  tss_pkg::sts_t    sts,
	output tss_pkg::cmd_t    cmd,
	output logic [AW-1:0]    wr_addr,
	output logic [AW-1:0]    rd_addr
);
	localparam int CW = $clog2(MAX_ROWS + 1);

	tss_pkg::state_t state_q, state_d;
	logic [CW-1:0]   rows_q;
	logic [AW-1:0]   idx_q;
	logic            first_q, last_q, sing_q, ovf_q;
	logic            full;

	assign full = (rows_q == CW'(MAX_ROWS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			tss_pkg::S_IDLE: begin
				if (in_valid) begin
					if (!full) begin
						state_d = tss_pkg::S_MULP;
					end else if (last_row) begin
						state_d = tss_pkg::S_BK_RD;
					end
				end
			end
			tss_pkg::S_MULP:   state_d = tss_pkg::S_MULQ;
			tss_pkg::S_MULQ:   state_d = tss_pkg::S_NUM;
			tss_pkg::S_NUM:    state_d = tss_pkg::S_DIV;
			tss_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_d = tss_pkg::S_STORE;
				end
			end
			tss_pkg::S_STORE:  state_d = last_q ? tss_pkg::S_BK_RD : tss_pkg::S_IDLE;
			tss_pkg::S_BK_RD:  state_d = tss_pkg::S_BK_MUL;
			tss_pkg::S_BK_MUL: state_d = tss_pkg::S_BK_ADD;
			tss_pkg::S_BK_ADD: state_d = tss_pkg::S_BK_OUT;
			tss_pkg::S_BK_OUT: begin
				if (out_ready) begin
					state_d = (idx_q == '0) ? tss_pkg::S_IDLE : tss_pkg::S_BK_RD;
				end
			end
			default: state_d = tss_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == tss_pkg::S_IDLE) && in_valid;
		cmd.mul_p     = (state_q == tss_pkg::S_MULP);
		cmd.mul_q     = (state_q == tss_pkg::S_MULQ);
		cmd.div_start = (state_q == tss_pkg::S_NUM);
		cmd.store     = (state_q == tss_pkg::S_STORE);
		cmd.last      = last_q;
		cmd.clear_run = (state_q == tss_pkg::S_BK_OUT) && out_ready && (idx_q == '0);
		cmd.bk_read   = (state_q == tss_pkg::S_BK_RD);
		cmd.bk_mul    = (state_q == tss_pkg::S_BK_MUL);
		cmd.bk_add    = (state_q == tss_pkg::S_BK_ADD);
		cmd.first     = first_q;
		in_ready      = (state_q == tss_pkg::S_IDLE);
		out_valid     = (state_q == tss_pkg::S_BK_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::S_IDLE;
			rows_q  <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			last_q  <= 1'b0;
			sing_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				last_q <= last_row;
				if (full) begin
					ovf_q <= 1'b1;
					if (last_row) begin
						idx_q   <= AW'(rows_q - CW'(1));
						first_q <= 1'b1;
					end
				end
			end
			if (cmd.store) begin
				rows_q <= rows_q + CW'(1);
				sing_q <= sing_q | sts.pivot_zero;
				if (last_q) begin
					idx_q   <= AW'(rows_q);
					first_q <= 1'b1;
				end
			end
			if (out_valid && out_ready) begin
				first_q <= 1'b0;
				if (idx_q == '0) begin
					rows_q <= '0;
					sing_q <= 1'b0;
					ovf_q  <= 1'b0;
				end else begin
					idx_q <= idx_q - AW'(1);
				end
			end
		end
	end

	assign wr_addr       = AW'(rows_q);
	assign rd_addr       = idx_q;
	assign row_index     = 6'(idx_q);
	assign final_element = (idx_q == '0);
	assign singular      = sing_q;
	assign overflowed    = ovf_q;

	`TSS_ASSERT(a_out_blocks_in, clk, arst_n, out_valid |-> !in_ready)
	`TSS_ASSERT(a_store_in_range, clk, arst_n, cmd.store |-> !full)
	`TSS_ASSERT(a_run_clears, clk, arst_n, cmd.clear_run |=> (rows_q == '0) && !sing_q && !ovf_q)
	`TSS_ASSERT_ALWAYS(a_rows_bound, clk, rows_q <= CW'(MAX_ROWS))
endmodule

// File: rtl/tridiagonal_system_solver.sv
// Thomas-algorithm tridiagonal solver in signed fixed point. Feed one matrix row
// per beat, row zero first, with last_row on the final row. Each stored row waits
// on the bit-serial divider (Q16.16 at the default FRAC_BITS), which forms both
// elimination coefficients at once. After the last row the solution streams from
// the last row down to row zero, an element only once the one before is taken; no
// row is taken during that pass. Rows beyond MAX_ROWS are dropped and flagged
// with overflowed; a zero pivot saturates and sets singular.
module tridiagonal_system_solver #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [tss_pkg::DW-1:0]  sub_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  main_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  super_diagonal,
	input  logic signed [tss_pkg::DW-1:0]  right_side,
	input  logic                           last_row,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [tss_pkg::DW-1:0]  solution,
	output logic [5:0]                     row_index,
	output logic                           final_element,
	output logic                           singular,
	output logic                           overflowed
);
	localparam int AW = $clog2(MAX_ROWS);

	tss_pkg::cmd_t cmd;
	tss_pkg::sts_t sts;
	logic [AW-1:0] wr_addr, rd_addr;

	tss_ctrl #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.last_row      (last_row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_index     (row_index),
		.final_element (final_element),
		.singular      (singular),
		.overflowed    (overflowed),
		.sts           (sts),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr)
	);

	tss_dpath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr),
		.sub_diagonal   (sub_diagonal),
		.main_diagonal  (main_diagonal),
		.super_diagonal (super_diagonal),
		.right_side     (right_side),
		.sts            (sts),
		.solution       (solution)
	);
endmodule
